// ===== sv/strided_slice_address_generator_assert.svh =====
// Assertion macros for the address generator top module.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef STRIDED_SLICE_ADDRESS_GENERATOR_ASSERT_SVH
`define STRIDED_SLICE_ADDRESS_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define SSAG_ASSERT_NOW(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("address generator check failed");

`define SSAG_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("address generator check failed");

`else

`define SSAG_ASSERT_NOW(lbl, ck, rn, prop)

`define SSAG_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ===== sv/ssag_pkg.sv =====
package ssag_pkg;

  localparam int NDIM   = 4;
  localparam int DIM_W  = 12;
  localparam int IDX_W  = 48;
  localparam int BOFF_W = 51;
  localparam int EB_W   = 4;
  localparam int RANK_W = 3;
  localparam int ST_W   = 2;
  localparam int CIDX_W = 3;
  localparam int PACK_W = NDIM * DIM_W;

  localparam logic [CIDX_W-1:0] REG_RANK    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_LDIMS   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_GDIMS   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_OFFSETS = 3'd3;
  localparam logic [CIDX_W-1:0] REG_STRIDES = 3'd4;
  localparam logic [CIDX_W-1:0] REG_EBYTES  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK          = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO_STRIDE = 2'd1;
  localparam logic [ST_W-1:0] ST_OUTSIDE     = 2'd2;
  localparam logic [ST_W-1:0] ST_BEYOND      = 2'd3;

  typedef logic [DIM_W-1:0] dim_t;
  typedef dim_t [NDIM-1:0] dims_t;

  // Payload that rides along the divider chain.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    dim_t             c2;
    dim_t             c3;
  } side_t;

  // Result of the coordinate mapping, handed to the recombination stages.
  typedef struct packed {
    logic             valid;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] idx;
    dims_t            gc;
  } mres_t;

  // Aligns the dimensions in use to the fast end; unused slow dimensions get pad.
  function automatic dims_t norm_dims(logic [PACK_W-1:0] packed_v,
                                      logic [RANK_W-1:0] rank, dim_t pad);
    dims_t res;
    int    r;
    int    src;
    r = (int'(rank) > NDIM) ? NDIM : int'(rank);
    for (int k = 0; k < NDIM; k++) begin
      src = k - (NDIM - r);
      if (src >= 0) begin
        res[k] = packed_v[(NDIM - 1 - src) * DIM_W +: DIM_W];
      end else begin
        res[k] = pad;
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/ssag_div.sv =====
module ssag_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [ssag_pkg::IDX_W-1:0] in_num,
  input  ssag_pkg::side_t           in_side,
  input  ssag_pkg::dim_t            divisor,
  output logic                      out_valid,
  output logic [ssag_pkg::IDX_W-1:0] out_quo,
  output ssag_pkg::dim_t            out_rem,
  output ssag_pkg::side_t           out_side
);
  import ssag_pkg::*;

  // Restoring division, one quotient bit per stage.
  logic [IDX_W-1:0] v_r;
  dim_t             rem_r  [IDX_W];
  dim_t             rem_nxt[IDX_W];
  dim_t             rem_in [IDX_W];
  logic [IDX_W-1:0] w_r    [IDX_W];
  logic [IDX_W-1:0] w_nxt  [IDX_W];
  logic [IDX_W-1:0] w_in   [IDX_W];
  logic [DIM_W:0]   trial  [IDX_W];
  logic             ge     [IDX_W];
  side_t            side_r [IDX_W];

  always_comb begin
    rem_in[0] = '0;
    w_in[0]   = in_num;
    for (int s = 1; s < IDX_W; s++) begin
      rem_in[s] = rem_r[s-1];
      w_in[s]   = w_r[s-1];
    end
    for (int s = 0; s < IDX_W; s++) begin
      trial[s]   = {rem_in[s], w_in[s][IDX_W-1]};
      ge[s]      = (trial[s] >= {1'b0, divisor});
      rem_nxt[s] = ge[s] ? DIM_W'(trial[s] - {1'b0, divisor}) : trial[s][DIM_W-1:0];
      w_nxt[s]   = {w_in[s][IDX_W-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[IDX_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int s = 1; s < IDX_W; s++) begin
        side_r[s] <= side_r[s-1];
      end
      for (int s = 0; s < IDX_W; s++) begin
        rem_r[s] <= rem_nxt[s];
        w_r[s]   <= w_nxt[s];
      end
    end
  end

  assign out_valid = v_r[IDX_W-1];
  assign out_quo   = w_r[IDX_W-1];
  assign out_rem   = rem_r[IDX_W-1];
  assign out_side  = side_r[IDX_W-1];

endmodule

// ===== sv/ssag_map.sv =====
module ssag_map (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  ssag_pkg::dims_t           coords,
  input  logic [ssag_pkg::IDX_W-1:0] quo,
  input  logic [ssag_pkg::IDX_W-1:0] idx,
  input  ssag_pkg::dim_t            ldim0,
  input  logic                      local_zero,
  input  ssag_pkg::dims_t           strides,
  input  ssag_pkg::dims_t           offsets,
  input  ssag_pkg::dims_t           gdims,
  output ssag_pkg::mres_t           res
);
  import ssag_pkg::*;

  logic                   v1_r;
  logic                   beyond_r;
  logic [IDX_W-1:0]       idx1_r;
  logic [2*DIM_W-1:0]     prod_r [NDIM];
  logic [2*DIM_W:0]       gcw    [NDIM];
  logic [ST_W-1:0]        code;
  mres_t                  res_r;
  mres_t                  res_nxt;

  // First stage: coordinate times stride, and the local count check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beyond_r <= local_zero || (quo >= IDX_W'(ldim0));
      idx1_r   <= idx;
      for (int k = 0; k < NDIM; k++) begin
        prod_r[k] <= coords[k] * strides[k];
      end
    end
  end

  // Second stage: add offsets; the lowest failing dimension sets the code.
  always_comb begin
    code = ST_OK;
    for (int k = NDIM - 1; k >= 0; k--) begin
      gcw[k] = (2*DIM_W+1)'(offsets[k]) + (2*DIM_W+1)'(prod_r[k]);
      if (strides[k] == '0) begin
        code = ST_ZERO_STRIDE;
      end else if (gcw[k] >= (2*DIM_W+1)'(gdims[k])) begin
        code = ST_OUTSIDE;
      end
    end
    res_nxt.valid  = v1_r;
    res_nxt.status = beyond_r ? ST_BEYOND : code;
    res_nxt.idx    = idx1_r;
    for (int k = 0; k < NDIM; k++) begin
      res_nxt.gc[k] = gcw[k][DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== sv/ssag_lin.sv =====
module ssag_lin (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  ssag_pkg::mres_t            in_res,
  input  ssag_pkg::dims_t            gdims,
  input  logic [ssag_pkg::EB_W-1:0]  ebytes,
  output logic                       out_valid,
  output logic [ssag_pkg::IDX_W-1:0] out_gidx,
  output logic [ssag_pkg::BOFF_W-1:0] out_gboff,
  output logic [ssag_pkg::BOFF_W-1:0] out_lboff,
  output logic [ssag_pkg::ST_W-1:0]  out_status
);
  import ssag_pkg::*;

  localparam int A_W = 2 * DIM_W;
  localparam int B_W = 3 * DIM_W;

  logic [2:0]       v_r;
  logic [ST_W-1:0]  st_r  [3];
  logic [IDX_W-1:0] idx_r [3];
  dim_t             gc2_r [1];
  dim_t             gc3_r [2];
  logic [A_W-1:0]   a_r;
  logic [B_W-1:0]   b_r;
  logic [IDX_W-1:0] c_r;
  logic             ov_r;
  logic [IDX_W-1:0] gidx_r;
  logic [BOFF_W-1:0] gboff_r;
  logic [BOFF_W-1:0] lboff_r;
  logic [ST_W-1:0]  ost_r;
  logic             ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[1:0], in_res.valid};
      ov_r <= v_r[2];
    end
  end

  assign ok = (st_r[2] == ST_OK);

  // Horner recombination over the global shape, one multiply-add per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= in_res.status;
      idx_r[0] <= in_res.idx;
      gc2_r[0] <= in_res.gc[2];
      gc3_r[0] <= in_res.gc[3];
      a_r      <= A_W'(in_res.gc[0] * gdims[1]) + A_W'(in_res.gc[1]);
      st_r[1]  <= st_r[0];
      idx_r[1] <= idx_r[0];
      gc3_r[1] <= gc3_r[0];
      b_r      <= B_W'(a_r * gdims[2]) + B_W'(gc2_r[0]);
      st_r[2]  <= st_r[1];
      idx_r[2] <= idx_r[1];
      c_r      <= IDX_W'(b_r * gdims[3]) + IDX_W'(gc3_r[1]);
      ost_r    <= st_r[2];
      gidx_r   <= ok ? c_r : '0;
      gboff_r  <= ok ? BOFF_W'(c_r * ebytes) : '0;
      lboff_r  <= ok ? BOFF_W'(idx_r[2] * ebytes) : '0;
    end
  end

  assign out_valid  = ov_r;
  assign out_gidx   = gidx_r;
  assign out_gboff  = gboff_r;
  assign out_lboff  = lboff_r;
  assign out_status = ost_r;

endmodule

// ===== sv/strided_slice_address_generator.sv =====
// Throughput: one item per cycle while no result is stalled; three 48-stage divider pipelines set the depth.
// The whole pipeline advances together and freezes only while a result is stalled.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the configuration
// registers with zero, except the element size, which becomes one.
module strided_slice_address_generator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ssag_pkg::IDX_W-1:0]   in_local_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ssag_pkg::IDX_W-1:0]   out_global_index,
  output logic [ssag_pkg::BOFF_W-1:0]  out_global_byte_offset,
  output logic [ssag_pkg::BOFF_W-1:0]  out_local_byte_offset,
  output logic [ssag_pkg::ST_W-1:0]    out_status,
  input  logic                         cfg_we,
  input  logic [ssag_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [ssag_pkg::PACK_W-1:0]  cfg_wdata
);
  import ssag_pkg::*;
  `include "strided_slice_address_generator_assert.svh"

  // Configuration registers. The user must write them only while the block is idle,
  // so the items in flight always see one consistent setting; the block does not enforce this.
  logic [RANK_W-1:0] cfg_rank_r;
  logic [PACK_W-1:0] cfg_ldims_r;
  logic [PACK_W-1:0] cfg_gdims_r;
  logic [PACK_W-1:0] cfg_offs_r;
  logic [PACK_W-1:0] cfg_strides_r;
  logic [EB_W-1:0]   cfg_ebytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rank_r    <= '0;
      cfg_ldims_r   <= '0;
      cfg_gdims_r   <= '0;
      cfg_offs_r    <= '0;
      cfg_strides_r <= '0;
      cfg_ebytes_r  <= EB_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANK:    cfg_rank_r    <= cfg_wdata[RANK_W-1:0];
        REG_LDIMS:   cfg_ldims_r   <= cfg_wdata;
        REG_GDIMS:   cfg_gdims_r   <= cfg_wdata;
        REG_OFFSETS: cfg_offs_r    <= cfg_wdata;
        REG_STRIDES: cfg_strides_r <= cfg_wdata;
        REG_EBYTES:  cfg_ebytes_r  <= cfg_wdata[EB_W-1:0];
        default: ;
      endcase
    end
  end

  // The dimensions in use are moved to the fast end of a fixed four-dimension
  // shape. The padding dimensions have local and global size one, stride one and
  // offset zero, so they always map to coordinate zero and leave the linear
  // index untouched. A rank of zero thus becomes a shape of all ones.
  dims_t ldims;
  dims_t gdims;
  dims_t offs;
  dims_t strides;
  logic  local_zero;

  always_comb begin
    ldims      = norm_dims(cfg_ldims_r,   cfg_rank_r, dim_t'(1));
    gdims      = norm_dims(cfg_gdims_r,   cfg_rank_r, dim_t'(1));
    offs       = norm_dims(cfg_offs_r,    cfg_rank_r, dim_t'(0));
    strides    = norm_dims(cfg_strides_r, cfg_rank_r, dim_t'(1));
    local_zero = 1'b0;
    for (int k = 0; k < NDIM; k++) begin
      if (ldims[k] == '0) begin
        local_zero = 1'b1;
      end
    end
  end

  // One shared advance for every stage: the pipeline moves unless the finished
  // item on the output is being held off.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // Mixed-radix split, last dimension first. Each divider yields one coordinate
  // as remainder; the final quotient is coordinate zero, and it also decides the
  // count check: the index is inside the slice exactly when it is below dim 0 and no size is zero.
  side_t            side_a;
  side_t            side_a_o;
  side_t            side_b;
  side_t            side_b_o;
  side_t            side_c;
  side_t            side_c_o;
  logic             va;
  logic             vb;
  logic             vc;
  logic [IDX_W-1:0] qa;
  logic [IDX_W-1:0] qb;
  logic [IDX_W-1:0] qc;
  dim_t             ra;
  dim_t             rb;
  dim_t             rc;

  always_comb begin
    side_a     = '0;
    side_a.idx = in_local_index;
    side_b     = side_a_o;
    side_b.c3  = ra;
    side_c     = side_b_o;
    side_c.c2  = rb;
  end

  ssag_div u_div3 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid && !in_stall), .in_num(in_local_index), .in_side(side_a),
    .divisor(ldims[3]),
    .out_valid(va), .out_quo(qa), .out_rem(ra), .out_side(side_a_o)
  );

  ssag_div u_div2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(va), .in_num(qa), .in_side(side_b),
    .divisor(ldims[2]),
    .out_valid(vb), .out_quo(qb), .out_rem(rb), .out_side(side_b_o)
  );

  ssag_div u_div1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vb), .in_num(qb), .in_side(side_c),
    .divisor(ldims[1]),
    .out_valid(vc), .out_quo(qc), .out_rem(rc), .out_side(side_c_o)
  );

  dims_t coords;
  always_comb begin
    coords[0] = qc[DIM_W-1:0];
    coords[1] = rc;
    coords[2] = side_c_o.c2;
    coords[3] = side_c_o.c3;
  end

  // Coordinate mapping and the status decision take two stages.
  mres_t mres;

  ssag_map u_map (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vc), .coords(coords), .quo(qc), .idx(side_c_o.idx),
    .ldim0(ldims[0]), .local_zero(local_zero),
    .strides(strides), .offsets(offs), .gdims(gdims),
    .res(mres)
  );

  // Recombination into the global index and byte scaling take four stages; the
  // last of them is the output register.
  ssag_lin u_lin (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_res(mres), .gdims(gdims), .ebytes(cfg_ebytes_r),
    .out_valid(out_valid), .out_gidx(out_global_index),
    .out_gboff(out_global_byte_offset), .out_lboff(out_local_byte_offset),
    .out_status(out_status)
  );

  // An item with an error status carries no addresses.
  `SSAG_ASSERT_NOW(a_err_zero, clk, rst_n, (out_valid && out_status != ST_OK) |-> (out_global_index == '0 && out_global_byte_offset == '0 && out_local_byte_offset == '0))
  // A result that is held off is still there in the next cycle.
  `SSAG_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid)
  // The input is held off only while the output is blocked.
  `SSAG_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall))
  // With an empty element type every byte offset is zero.
  `SSAG_ASSERT_NOW(a_empty_elem, clk, rst_n, (out_valid && cfg_ebytes_r == '0) |-> (out_local_byte_offset == '0 && out_global_byte_offset == '0))

endmodule

// ===== tb/strided_slice_address_generator_tb.sv =====
module strided_slice_address_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssag_pkg::*;

  // One expected address result, in the field widths of the output ports.
  typedef struct {
    logic [IDX_W-1:0]  global_index;
    logic [BOFF_W-1:0] global_byte_offset;
    logic [BOFF_W-1:0] local_byte_offset;
    logic [ST_W-1:0]   status;
  } addr_result_t;

  localparam logic [PACK_W-1:0] ALL_ONES = {PACK_W{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [IDX_W-1:0] in_local_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_global_index;
  logic [BOFF_W-1:0] out_global_byte_offset;
  logic [BOFF_W-1:0] out_local_byte_offset;
  logic [ST_W-1:0] out_status;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [PACK_W-1:0] cfg_wdata = '0;

  strided_slice_address_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_local_index(in_local_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_global_index(out_global_index),
    .out_global_byte_offset(out_global_byte_offset),
    .out_local_byte_offset(out_local_byte_offset),
    .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Our own copy of the configuration registers, starting from reset values.
  logic [RANK_W-1:0] shadow_rank = '0;
  logic [PACK_W-1:0] shadow_local = '0;
  logic [PACK_W-1:0] shadow_global = '0;
  logic [PACK_W-1:0] shadow_offsets = '0;
  logic [PACK_W-1:0] shadow_strides = '0;
  logic [EB_W-1:0]   shadow_ebytes = EB_W'(1);

  logic [IDX_W-1:0] pending_indices[$];
  addr_result_t     expected_addrs[$];
  int mismatch_count = 0;

  // Idle pacing state. The burst flags switch idling off for a whole phase.
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int tx_gap = 0;
  int rx_hold = 0;
  bit in_taken = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Appends one index to the list of items still to be driven.
  task automatic queue_index(logic [IDX_W-1:0] v);
    pending_indices.insert(pending_indices.size(), v);
  endtask

  // Dimension d sits in the top bits for d = 0, matching the packed registers.
  function automatic logic [63:0] dim_field(logic [PACK_W-1:0] packed_v, int d);
    return 64'(packed_v[(NDIM - 1 - d) * DIM_W +: DIM_W]);
  endfunction

  function automatic int used_rank();
    return (int'(shadow_rank) > NDIM) ? NDIM : int'(shadow_rank);
  endfunction

  // Number of elements in the local slice; a rank of zero is a scalar.
  function automatic logic [63:0] slice_count();
    logic [63:0] cnt;
    cnt = 1;
    for (int d = 0; d < used_rank(); d++) cnt = cnt * dim_field(shadow_local, d);
    return cnt;
  endfunction

  // Maps one local index to its global address under the current settings.
  function automatic addr_result_t compute_address(logic [IDX_W-1:0] idx);
    addr_result_t res;
    logic [63:0] coord[NDIM];
    logic [63:0] rem;
    logic [63:0] glin;
    logic [63:0] gc;
    logic [63:0] ld;
    logic [63:0] st;
    logic [63:0] gd;
    logic [ST_W-1:0] status;
    int r;
    r = used_rank();
    status = ST_OK;
    glin = 0;
    if (64'(idx) >= slice_count()) begin
      status = ST_BEYOND;
    end else begin
      // Mixed-radix split, last dimension fastest. No size is zero here.
      rem = 64'(idx);
      for (int d = r - 1; d >= 0; d--) begin
        ld = dim_field(shadow_local, d);
        coord[d] = rem % ld;
        rem = rem / ld;
      end
      // The first failing dimension, counted from zero, decides the status.
      for (int d = 0; d < r; d++) begin
        st = dim_field(shadow_strides, d);
        gd = dim_field(shadow_global, d);
        if (st == 0) begin
          status = ST_ZERO_STRIDE;
          break;
        end
        gc = dim_field(shadow_offsets, d) + coord[d] * st;
        if (gc >= gd) begin
          status = ST_OUTSIDE;
          break;
        end
        glin = glin * gd + gc;
      end
    end
    res.status = status;
    if (status != ST_OK) begin
      res.global_index = '0;
      res.global_byte_offset = '0;
      res.local_byte_offset = '0;
    end else begin
      res.global_index = glin[IDX_W-1:0];
      res.global_byte_offset = BOFF_W'(glin * 64'(shadow_ebytes));
      res.local_byte_offset = BOFF_W'(64'(idx) * 64'(shadow_ebytes));
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h", field, $realtime, got,
             want);
    mismatch_count++;
  endtask

  // Monitor: record accepted items and check accepted results at the rising edge.
  always @(posedge clk) begin
    addr_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_addrs.insert(expected_addrs.size(), compute_address(in_local_index));
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_addrs.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_status), 0);
        end else begin
          want = expected_addrs.pop_front();
          if (out_global_index !== want.global_index)
            report_mismatch("global_index", 64'(out_global_index), 64'(want.global_index));
          if (out_global_byte_offset !== want.global_byte_offset)
            report_mismatch("global_byte_offset", 64'(out_global_byte_offset),
                            64'(want.global_byte_offset));
          if (out_local_byte_offset !== want.local_byte_offset)
            report_mismatch("local_byte_offset", 64'(out_local_byte_offset),
                            64'(want.local_byte_offset));
          if (out_status !== want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
        end
        rx_hold = rx_burst ? 0 : $urandom_range(0, 17);
      end
    end
  end

  // Driver: an offered item stays put until taken, then a random gap follows.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        in_valid <= 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_indices.size() > 0) begin
        in_local_index <= pending_indices.pop_front();
        in_valid <= 1'b1;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 17);
      end else begin
        in_valid <= 1'b0;
      end
      in_taken = 1'b0;
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Register writes happen only from the stimulus process while the block is idle.
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [PACK_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_RANK:    shadow_rank = value[RANK_W-1:0];
      REG_LDIMS:   shadow_local = value;
      REG_GDIMS:   shadow_global = value;
      REG_OFFSETS: shadow_offsets = value;
      REG_STRIDES: shadow_strides = value;
      REG_EBYTES:  shadow_ebytes = value[EB_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [RANK_W-1:0] r, logic [PACK_W-1:0] ld,
                           logic [PACK_W-1:0] gd, logic [PACK_W-1:0] off,
                           logic [PACK_W-1:0] st, logic [EB_W-1:0] eb);
    write_reg(REG_RANK, PACK_W'(r));
    write_reg(REG_LDIMS, ld);
    write_reg(REG_GDIMS, gd);
    write_reg(REG_OFFSETS, off);
    write_reg(REG_STRIDES, st);
    write_reg(REG_EBYTES, PACK_W'(eb));
  endtask

  // Mostly a slice that fits inside the global tensor, with the odd zero size,
  // zero stride, full-size dimension or overhanging slice thrown in.
  task automatic random_setting();
    logic [PACK_W-1:0] ld;
    logic [PACK_W-1:0] gd;
    logic [PACK_W-1:0] off;
    logic [PACK_W-1:0] st;
    int l;
    int s;
    int o;
    int g;
    for (int d = 0; d < NDIM; d++) begin
      case ($urandom_range(0, 11))
        0: l = 0;
        1: l = 4095;
        default: l = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0: s = 0;
        1: s = 4095;
        default: s = $urandom_range(1, 3);
      endcase
      o = ($urandom_range(0, 15) == 0) ? 4095 : $urandom_range(0, 20);
      g = o + ((l > 0) ? l - 1 : 0) * s + 1 + $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) g = g - $urandom_range(1, 3);
      if ($urandom_range(0, 7) == 0) g = $urandom_range(0, 4095);
      if (g > 4095) g = 4095;
      if (g < 0) g = 0;
      ld[(NDIM - 1 - d) * DIM_W +: DIM_W] = DIM_W'(l);
      gd[(NDIM - 1 - d) * DIM_W +: DIM_W] = DIM_W'(g);
      off[(NDIM - 1 - d) * DIM_W +: DIM_W] = DIM_W'(o);
      st[(NDIM - 1 - d) * DIM_W +: DIM_W] = DIM_W'(s);
    end
    if ($urandom_range(0, 9) == 0) begin
      ld = PACK_W'({$urandom(), $urandom()});
      gd = PACK_W'({$urandom(), $urandom()});
      off = PACK_W'({$urandom(), $urandom()});
      st = PACK_W'({$urandom(), $urandom()});
    end
    write_all(RANK_W'($urandom_range(0, 7)), ld, gd, off, st, EB_W'($urandom_range(0, 15)));
  endtask

  // Indices are mostly inside the slice, with some at and past the count.
  task automatic queue_random_items(int n);
    logic [63:0] cnt;
    logic [63:0] raw;
    cnt = slice_count();
    for (int i = 0; i < n; i++) begin
      raw = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
        0: queue_index(raw[IDX_W-1:0]);
        1: queue_index(IDX_W'(cnt + $urandom_range(0, 3)));
        2: queue_index(IDX_W'((cnt > 0) ? cnt - 1 : 0));
        default: queue_index(IDX_W'((cnt > 0) ? raw % cnt : 0));
      endcase
    end
  endtask

  // Every item gives exactly one result, so an empty scoreboard means idle.
  task automatic wait_idle();
    wait (pending_indices.size() == 0 && !in_valid && expected_addrs.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a scalar tensor with one-byte elements.
    queue_index('0);
    queue_index(IDX_W'(1));
    queue_index({IDX_W{1'b1}});
    wait_idle();

    // Largest shape everywhere: index extremes around the full count, and the
    // widest element size so the byte offsets wrap.
    write_all(RANK_W'(4), ALL_ONES, ALL_ONES, '0, {NDIM{DIM_W'(1)}}, EB_W'(15));
    queue_index('0);
    queue_index(IDX_W'(slice_count() - 1));
    queue_index(IDX_W'(slice_count()));
    queue_index({IDX_W{1'b1}});
    wait_idle();

    // A rank above the maximum saturates; a zero stride in dimension two, and
    // with large strides every nonzero coordinate falls outside the global shape.
    write_all(RANK_W'(7), {NDIM{DIM_W'(3)}}, {NDIM{DIM_W'(9)}}, {NDIM{DIM_W'(1)}},
              {DIM_W'(2), DIM_W'(2), DIM_W'(0), DIM_W'(2)}, EB_W'(0));
    for (int i = 0; i < 10; i++) queue_index(IDX_W'(i * 9));
    wait_idle();
    write_reg(REG_STRIDES, ALL_ONES);
    write_reg(REG_EBYTES, PACK_W'(8));
    for (int i = 0; i < 4; i++) queue_index(IDX_W'(i));
    wait_idle();

    // A zero local size empties the slice.
    write_reg(REG_LDIMS, {DIM_W'(2), DIM_W'(0), DIM_W'(2), DIM_W'(2)});
    queue_index('0);
    queue_index(IDX_W'(5));
    wait_idle();

    for (int phase = 0; phase < 28; phase++) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      random_setting();
      queue_random_items(25);
      wait_idle();
    end

    repeat (200) @(negedge clk);
    if (mismatch_count == 0 && expected_addrs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== strided_slice_address_generator.f =====
+incdir+sv
sv/ssag_pkg.sv
sv/ssag_div.sv
sv/ssag_map.sv
sv/ssag_lin.sv
sv/strided_slice_address_generator.sv
tb/strided_slice_address_generator_tb.sv
